FILE: rtl/tbpf_pkg.sv
// ============================================================================
// Tiled background pixel fetch: shared package
// Request and result codes, register indexes, widths and the structs that
// travel between the modules of the fetch block.
// ============================================================================
`default_nettype none

package tbpf_pkg;

   // Field widths of the channels.
   localparam int REQ_TYPE_W   = 2;
   localparam int PIXEL_W      = 8;
   localparam int MEM_DATA_W   = 16;
   localparam int KIND_W       = 2;
   localparam int ADDR_W       = 17;
   localparam int VALUE_W      = 12;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 10;

   // Tile data addresses are computed one bit wider so that a crossing into
   // object memory can be seen.
   localparam int TILE_ADDR_W  = 18;
   localparam logic [TILE_ADDR_W-1:0] OBJ_MEM_START = 18'h10000;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_PIXEL = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_MAP   = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TILE  = 2'd2;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_MAP_ADDR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TILE_ADDR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_VALUE     = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_BASE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_8BPP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_BASE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_SIZE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_X    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_Y    = 3'd5;

   localparam logic [1:0] SIZE_WIDE_TALL = 2'd3;

   typedef struct packed {
      logic [1:0] tile_base;
      logic       color_8bpp;
      logic [4:0] map_base;
      logic [1:0] map_size;
      logic [9:0] scroll_x;
      logic [9:0] scroll_y;
   } cfg_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [PIXEL_W-1:0]    pixel_x;
      logic [PIXEL_W-1:0]    pixel_y;
      logic [MEM_DATA_W-1:0] mem_data;
   } item_type;

   typedef struct packed {
      logic [KIND_W-1:0]  result_kind;
      logic [ADDR_W-1:0]  mem_address;
      logic [VALUE_W-1:0] layer_value;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/tbpf_if.sv
// ============================================================================
// Tiled background pixel fetch: channel interfaces
// Valid/ready channels for requests, results and register writes.
// ============================================================================
`default_nettype none

interface tbpf_req_if;
   logic                             valid;
   logic                             ready;
   logic [tbpf_pkg::REQ_TYPE_W-1:0]  req_type;
   logic [tbpf_pkg::PIXEL_W-1:0]     pixel_x;
   logic [tbpf_pkg::PIXEL_W-1:0]     pixel_y;
   logic [tbpf_pkg::MEM_DATA_W-1:0]  mem_data;

   modport source (output valid, req_type, pixel_x, pixel_y, mem_data, input ready);
   modport sink   (input valid, req_type, pixel_x, pixel_y, mem_data, output ready);
endinterface

interface tbpf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tbpf_pkg::KIND_W-1:0]   result_kind;
   logic [tbpf_pkg::ADDR_W-1:0]   mem_address;
   logic [tbpf_pkg::VALUE_W-1:0]  layer_value;

   modport source (output valid, result_kind, mem_address, layer_value, input ready);
   modport sink   (input valid, result_kind, mem_address, layer_value, output ready);
endinterface

interface tbpf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tbpf_pkg::CSR_IDX_W-1:0]   index;
   logic [tbpf_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tbpf_csr.sv
// ============================================================================
// Tiled background pixel fetch: configuration registers
// Holds the layer setup; writes to unknown indexes are taken and dropped.
// ============================================================================
`default_nettype none

module tbpf_csr (
   input  wire logic         clock,
   input  wire logic         reset,
   tbpf_csr_if.sink          csr_bus,
   output tbpf_pkg::cfg_type cfg
);

   tbpf_pkg::cfg_type cfg_ff;
   tbpf_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            tbpf_pkg::CSR_CHAR_BASE:   cfg_in.tile_base  = csr_bus.data[1:0];
            tbpf_pkg::CSR_COLOR_8BPP:  cfg_in.color_8bpp = csr_bus.data[0];
            tbpf_pkg::CSR_SCREEN_BASE: cfg_in.map_base   = csr_bus.data[4:0];
            tbpf_pkg::CSR_SCREEN_SIZE: cfg_in.map_size   = csr_bus.data[1:0];
            tbpf_pkg::CSR_SCROLL_X:    cfg_in.scroll_x   = csr_bus.data[9:0];
            tbpf_pkg::CSR_SCROLL_Y:    cfg_in.scroll_y   = csr_bus.data[9:0];
            default:                   cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tbpf_fetch.sv
// ============================================================================
// Tiled background pixel fetch: step datapath
// Computes the result of one request and keeps the per-pixel fetch state.
// ============================================================================
`default_nettype none

module tbpf_fetch (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire tbpf_pkg::item_type item,
   input  wire tbpf_pkg::cfg_type  cfg,
   output tbpf_pkg::result_type    result,
   output logic                    has_result
);

   logic [2:0] fine_col_ff, fine_col_in;
   logic [2:0] fine_row_ff, fine_row_in;
   logic       high_nibble_ff, high_nibble_in;
   logic [3:0] pal_bank_ff, pal_bank_in;

   logic [10:0] sum_x;
   logic [10:0] sum_y;
   logic        blk_x;
   logic        blk_y;
   logic [1:0]  blk;
   logic [5:0]  map_block;
   logic [16:0] map_addr;

   logic [2:0]  tx;
   logic [2:0]  ty;
   logic [3:0]  pal_new;
   logic [15:0] off_8bpp;
   logic [14:0] off_4bpp;
   logic [17:0] tile_addr;
   logic        crossing;
   logic [3:0]  nibble;

   // Map position: the wrap to 256 or 512 pixels leaves bit 8 only on a
   // wide or tall map, where it moves on to a following screen block.
   always_comb begin
      sum_x     = {3'b000, item.pixel_x} + {1'b0, cfg.scroll_x};
      sum_y     = {3'b000, item.pixel_y} + {1'b0, cfg.scroll_y};
      blk_x     = cfg.map_size[0] & sum_x[8];
      blk_y     = cfg.map_size[1] & sum_y[8];
      blk       = (cfg.map_size == tbpf_pkg::SIZE_WIDE_TALL) ? {blk_y, blk_x}
                                                             : {1'b0, blk_x | blk_y};
      map_block = {1'b0, cfg.map_base} + {4'b0000, blk};
      map_addr  = {map_block, sum_y[7:3], sum_x[7:3], 1'b0};
   end

   // Tile data address with flips applied. The tile data base moves in steps
   // of 16 KiB.
   always_comb begin
      tx        = item.mem_data[10] ? ~fine_col_ff : fine_col_ff;
      ty        = item.mem_data[11] ? ~fine_row_ff : fine_row_ff;
      pal_new   = item.mem_data[15:12];
      off_8bpp  = {item.mem_data[9:0], ty, tx};
      off_4bpp  = {item.mem_data[9:0], ty, tx[2:1]};
      tile_addr = {2'b00, cfg.tile_base, 14'h0000}
                + (cfg.color_8bpp ? {2'b00, off_8bpp} : {3'b000, off_4bpp});
      crossing  = (tile_addr >= tbpf_pkg::OBJ_MEM_START);
      nibble    = high_nibble_ff ? item.mem_data[7:4] : item.mem_data[3:0];
   end

   always_comb begin
      fine_col_in    = fine_col_ff;
      fine_row_in    = fine_row_ff;
      high_nibble_in = high_nibble_ff;
      pal_bank_in    = pal_bank_ff;
      result         = '0;
      has_result     = 1'b1;
      unique case (item.req_type)
         tbpf_pkg::REQ_PIXEL: begin
            fine_col_in        = sum_x[2:0];
            fine_row_in        = sum_y[2:0];
            result.result_kind = tbpf_pkg::KIND_MAP_ADDR;
            result.mem_address = map_addr;
         end
         tbpf_pkg::REQ_MAP: begin
            fine_col_in    = tx;
            fine_row_in    = ty;
            pal_bank_in    = pal_new;
            high_nibble_in = ~cfg.color_8bpp & tx[0];
            if (crossing) begin
               result.result_kind = tbpf_pkg::KIND_VALUE;
               result.layer_value = cfg.color_8bpp ? 12'h000 : {pal_new, 8'h00};
            end else begin
               result.result_kind = tbpf_pkg::KIND_TILE_ADDR;
               result.mem_address = tile_addr[16:0];
            end
         end
         tbpf_pkg::REQ_TILE: begin
            result.result_kind = tbpf_pkg::KIND_VALUE;
            result.layer_value = cfg.color_8bpp ? {4'h0, item.mem_data[7:0]}
                                                : {pal_bank_ff, 4'h0, nibble};
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fine_col_ff    <= '0;
         fine_row_ff    <= '0;
         high_nibble_ff <= 1'b0;
         pal_bank_ff    <= '0;
      end else if (advance) begin
         fine_col_ff    <= fine_col_in;
         fine_row_ff    <= fine_row_in;
         high_nibble_ff <= high_nibble_in;
         pal_bank_ff    <= pal_bank_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tiled_background_pixel_fetch.sv
// ============================================================================
// Tiled background pixel fetch
// Address and pixel logic for one text background layer, driven by a
// three-step exchange with video memory.
// ============================================================================
//
//   Channel   Direction  Carries
//   req_bus   in         request type, pixel position, memory word
//   rsp_bus   out        result kind, memory byte address, layer value
//   csr_bus   in         register index and write data
//
// One request transfer can be taken on every clock cycle while results are
// taken. A transferred request is held in the input register, and its result
// is loaded into the output register when it moves on; the output register
// offers the result until it transfers.
// Reset is synchronous and clears the valid flags of both registers, the fetch
// state and the configuration; the payload registers are not reset.
// A stalled result holds the output register; the input register then takes
// at most one more request, and once it is full the request channel deasserts
// ready until the result leaves.
// A request of the unknown type is taken and leaves no result.
// ============================================================================
`default_nettype none

module tiled_background_pixel_fetch (
   input  wire logic clock,
   input  wire logic reset,
   tbpf_req_if.sink  req_bus,
   tbpf_rsp_if.source rsp_bus,
   tbpf_csr_if.sink  csr_bus
);

   tbpf_pkg::cfg_type    cfg;
   tbpf_pkg::item_type   item_ff;
   tbpf_pkg::item_type   item_in;
   logic                 item_valid_ff;
   logic                 item_valid_in;
   tbpf_pkg::result_type result;
   tbpf_pkg::result_type result_ff;
   tbpf_pkg::result_type result_in;
   logic                 result_valid_ff;
   logic                 result_valid_in;
   logic                 has_result;
   logic                 advance;
   logic                 req_transfer;

   tbpf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // The held request moves on as soon as the output register is free or is
   // being emptied in this cycle. The fetch state follows the same strobe, so
   // requests see the state in their arrival order.
   assign advance       = item_valid_ff & (~result_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~item_valid_ff | advance;
   assign req_transfer  = req_bus.valid & req_bus.ready;

   tbpf_fetch u_fetch (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (item_ff),
      .cfg        (cfg),
      .result     (result),
      .has_result (has_result)
   );

   always_comb begin
      item_in.req_type = req_bus.req_type;
      item_in.pixel_x  = req_bus.pixel_x;
      item_in.pixel_y  = req_bus.pixel_y;
      item_in.mem_data = req_bus.mem_data;

      item_valid_in = item_valid_ff;
      if (req_transfer) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end

      result_in       = result_ff;
      result_valid_in = result_valid_ff;
      if (advance) begin
         result_in       = result;
         result_valid_in = has_result;
      end else if (rsp_bus.ready) begin
         result_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         item_valid_ff   <= item_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         item_ff <= item_in;
      end
      result_ff <= result_in;
   end

   assign rsp_bus.valid       = result_valid_ff;
   assign rsp_bus.result_kind = result_ff.result_kind;
   assign rsp_bus.mem_address = result_ff.mem_address;
   assign rsp_bus.layer_value = result_ff.layer_value;

endmodule

`default_nettype wire

FILE: rtl/tbpf_checker.sv
// ============================================================================
// Tiled background pixel fetch: port checker
// Watches the request and result ports of the top level over time.
// ============================================================================
`default_nettype none

module tbpf_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [tbpf_pkg::KIND_W-1:0]   result_kind,
   input wire logic [tbpf_pkg::ADDR_W-1:0]   mem_address,
   input wire logic [tbpf_pkg::VALUE_W-1:0]  layer_value
);

   // A result held back by the consumer stays as it is.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_kind)
         && $stable(mem_address) && $stable(layer_value))
      else $error("stalled result changed");

   // No result is offered in the cycle after reset.
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // A result that appears on an idle output comes from an earlier request transfer.
   a_rsp_origin : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) && !$past(reset) && !$past(reset, 2)
         |-> $past(req_valid && req_ready, 2))
      else $error("result without a request");

   // Addresses and values are exclusive by result kind.
   a_kind_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (result_kind == tbpf_pkg::KIND_VALUE && mem_address == '0)
         || ((result_kind == tbpf_pkg::KIND_MAP_ADDR
              || result_kind == tbpf_pkg::KIND_TILE_ADDR) && layer_value == '0))
      else $error("result fields do not match the kind");

endmodule

bind tiled_background_pixel_fetch tbpf_checker u_tbpf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .result_kind (rsp_bus.result_kind),
   .mem_address (rsp_bus.mem_address),
   .layer_value (rsp_bus.layer_value)
);

`default_nettype wire
